// ===== sv/fla_pkg.sv =====
// ----------------------------------------------------------------------------
// fla_pkg: shared types and codes of the free-list allocator
// Function and status codes, field widths and the sequencer state type.
// ----------------------------------------------------------------------------
package fla_pkg;

    localparam int FUNC_W  = 2;
    localparam int STAT_W  = 2;
    localparam int REQ_W   = 15;
    localparam int ADDR_W  = 15;
    localparam int BYTES_W = 16;
    localparam int CFG_W   = 13;
    localparam int DIV_W   = 16;

    localparam logic [FUNC_W-1:0] FN_ALLOC = 2'd0;
    localparam logic [FUNC_W-1:0] FN_FREE  = 2'd1;
    localparam logic [FUNC_W-1:0] FN_STATS = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOFIT   = 2'd1;
    localparam logic [STAT_W-1:0] ST_BADADDR = 2'd2;
    localparam logic [STAT_W-1:0] ST_SCAN    = 2'd3;

    typedef enum logic [4:0] {
        S_CLR,
        S_IDLE,
        S_DIV,
        S_A_HEAD,
        S_A_HW,
        S_A_RD,
        S_A_EV,
        S_A_W2,
        S_F_RD,
        S_F_EV,
        S_F_RB,
        S_F_RU,
        S_F_RP,
        S_F_WP,
        S_S_HEAD,
        S_S_HW,
        S_S_RD,
        S_S_EV,
        S_DONE
    } t_state;

endpackage

// ===== sv/fla_div.sv =====
// ----------------------------------------------------------------------------
// fla_div: divide by the unit size
// Reciprocal multiply by a constant; o_done pulses in the cycle after i_start
// with quotient and remainder.
// ----------------------------------------------------------------------------
module fla_div #(
    parameter int UNIT_BYTES = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [fla_pkg::DIV_W-1:0]      i_dividend,
    output logic                           o_done,
    output logic [fla_pkg::DIV_W-1:0]      o_quot,
    output logic [$clog2(UNIT_BYTES):0]    o_rem
);

    localparam int RW = $clog2(UNIT_BYTES) + 1;
    localparam int DW = fla_pkg::DIV_W;
    localparam int SH = DW + $clog2(UNIT_BYTES);
    localparam int PW = SH + DW;
    localparam longint unsigned RECIP =
        ((64'd1 << SH) + 64'(UNIT_BYTES) - 64'd1) / 64'(UNIT_BYTES);

    logic [PW-1:0] w_prod;
    logic [DW-1:0] w_q, w_qd;
    logic [RW-1:0] w_r;
    logic          r_done;
    logic [DW-1:0] r_quot;
    logic [RW-1:0] r_rem;

    assign w_prod = PW'(i_dividend) * PW'(RECIP);
    assign w_q    = w_prod[SH +: DW];
    assign w_qd   = w_q * DW'(UNIT_BYTES);
    assign w_r    = RW'(i_dividend - w_qd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
        if (i_start) begin
            r_quot <= w_q;
            r_rem  <= w_r;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

// ===== sv/free_list_heap_allocator.sv =====
// ----------------------------------------------------------------------------
// free_list_heap_allocator: first-fit free-list heap allocator
// Address-ordered circular free list with sentinel and roving pointer.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on i_valid/o_ready with i_func, i_request_bytes and
//   i_release_address. Each request produces one result on o_valid/i_ready.
//   One request is in work at a time; o_ready is high only when idle.
//   Allocate and free first divide by the unit size. Allocate then walks
//   the free runs and writes one more header when the run is split; free
//   walks the list nodes, then reads and writes the neighbour headers;
//   statistics walks every free run. A bad address returns straight after
//   the divide. Each walk reads one header per node from the header
//   memories.
//   A finished result waits in the output register; the sequencer holds in
//   its final state while the receiver stalls and the register is full.
//   Reset and every write of i_cfg_we rebuild the pool with a clearing pass
//   over all POOL_UNITS+1 header entries, no request accepted.
// ----------------------------------------------------------------------------
module free_list_heap_allocator #(
    parameter int POOL_UNITS = 4096,
    parameter int UNIT_BYTES = 8,
    parameter int SCAN_LIMIT = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [fla_pkg::FUNC_W-1:0]    i_func,
    input  logic [fla_pkg::REQ_W-1:0]     i_request_bytes,
    input  logic [fla_pkg::ADDR_W-1:0]    i_release_address,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [fla_pkg::STAT_W-1:0]    o_status,
    output logic [fla_pkg::ADDR_W-1:0]    o_granted_address,
    output logic [fla_pkg::BYTES_W-1:0]   o_total_bytes,
    output logic [fla_pkg::BYTES_W-1:0]   o_free_bytes,
    output logic [fla_pkg::BYTES_W-1:0]   o_used_bytes,
    input  logic                          i_cfg_we,
    input  logic [fla_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int IW    = $clog2(POOL_UNITS + 1);
    localparam int DEPTH = POOL_UNITS + 1;
    localparam int SW    = (IW > fla_pkg::DIV_W ? IW : fla_pkg::DIV_W) + 2;
    localparam int CW    = $clog2(SCAN_LIMIT + 1) + 1;
    localparam int RW    = $clog2(UNIT_BYTES) + 1;
    localparam int NW    = fla_pkg::DIV_W;

    fla_pkg::t_state r_state, n_state;

    logic [IW-1:0] link_mem  [DEPTH];
    logic [IW-1:0] units_mem [DEPTH];
    logic [IW-1:0] r_link_q, r_units_q;

    logic          w_link_we, w_units_we;
    logic [IW-1:0] w_link_wa, w_units_wa, w_link_wd, w_units_wd, w_rd_addr;

    logic [IW-1:0] r_clr_idx, n_clr_idx;
    logic [IW-1:0] r_pool, n_pool;
    logic [IW-1:0] r_rover, n_rover;
    logic [fla_pkg::FUNC_W-1:0] r_func, n_func;
    logic [NW-1:0] r_need, n_need;
    logic [IW-1:0] r_prev, n_prev;
    logic [IW-1:0] r_p, n_p;
    logic [IW-1:0] r_bp, n_bp;
    logic [IW-1:0] r_up, n_up;
    logic [IW-1:0] r_ub, n_ub;
    logic [IW-1:0] r_nub, n_nub;
    logic [IW-1:0] r_nlb, n_nlb;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [IW-1:0] r_sum, n_sum;
    logic [fla_pkg::STAT_W-1:0] r_status, n_status;
    logic [fla_pkg::ADDR_W-1:0] r_grant, n_grant;

    logic                          r_ov, n_ov;
    logic [fla_pkg::STAT_W-1:0]    r_o_status, n_o_status;
    logic [fla_pkg::ADDR_W-1:0]    r_o_grant, n_o_grant;
    logic [fla_pkg::BYTES_W-1:0]   r_o_total, n_o_total;
    logic [fla_pkg::BYTES_W-1:0]   r_o_free, n_o_free;
    logic [fla_pkg::BYTES_W-1:0]   r_o_used, n_o_used;

    logic                 w_div_start, w_div_done;
    logic [NW-1:0]        w_div_dividend, w_div_q;
    logic [RW-1:0]        w_div_r;

    logic          w_accept, w_out_free, w_clr_last;
    logic [IW-1:0] w_cfg_pool;
    logic [SW-1:0] w_s_pool, w_s_u, w_fit_top, w_su, w_sl, w_ss;
    logic          w_fit, w_brk, w_mu, w_ml, w_bad;
    logic [IW-1:0] w_su_sat, w_sl_sat, w_ss_sat;
    logic [NW-1:0] w_payload;
    logic [31:0]   w_grant_p, w_grant_p2, w_total, w_freeb;

    fla_div #(
        .UNIT_BYTES (UNIT_BYTES)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .o_done     (w_div_done),
        .o_quot     (w_div_q),
        .o_rem      (w_div_r)
    );

    assign o_ready    = (r_state == fla_pkg::S_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_ov || i_ready;
    assign w_clr_last = (r_clr_idx == IW'(POOL_UNITS));

    always_comb begin
        if (32'(i_cfg_data) < 32'd2) begin
            w_cfg_pool = IW'(2);
        end else if (32'(i_cfg_data) > 32'(POOL_UNITS)) begin
            w_cfg_pool = IW'(POOL_UNITS);
        end else begin
            w_cfg_pool = IW'(i_cfg_data);
        end
    end

    assign w_div_start    = w_accept && (i_func == fla_pkg::FN_ALLOC ||
                                         i_func == fla_pkg::FN_FREE);
    assign w_div_dividend = (i_func == fla_pkg::FN_ALLOC) ?
                            NW'(i_request_bytes) + NW'(UNIT_BYTES - 1) :
                            NW'(i_release_address);

    assign w_payload = (w_div_q == '0) ? NW'(1) : w_div_q;
    assign w_bad     = (w_div_r != '0) || (w_div_q == '0) ||
                       (SW'(w_div_q) > SW'(r_pool));

    assign w_s_pool  = SW'(r_pool);
    assign w_s_u     = SW'(r_units_q);
    assign w_fit_top = SW'(r_p) + w_s_u - SW'(r_need);
    assign w_fit     = (r_p != '0) && (w_s_u >= SW'(r_need)) && (w_fit_top <= w_s_pool);

    assign w_brk = ((r_bp > r_p) && (r_bp < r_link_q)) ||
                   ((r_p >= r_link_q) && ((r_bp > r_p) || (r_bp < r_link_q)));

    assign w_mu     = (SW'(r_bp) + SW'(r_ub) == SW'(r_up));
    assign w_su     = SW'(r_ub) + w_s_u;
    assign w_su_sat = (w_su > w_s_pool) ? r_pool : IW'(w_su);
    assign w_ml     = (SW'(r_p) + w_s_u == SW'(r_bp));
    assign w_sl     = w_s_u + SW'(r_nub);
    assign w_sl_sat = (w_sl > w_s_pool) ? r_pool : IW'(w_sl);
    assign w_ss     = SW'(r_sum) + w_s_u;
    assign w_ss_sat = (w_ss > w_s_pool) ? r_pool : IW'(w_ss);

    assign w_grant_p  = 32'(r_p) * 32'(UNIT_BYTES);
    assign w_grant_p2 = 32'(IW'(w_fit_top)) * 32'(UNIT_BYTES);
    assign w_total    = 32'(r_pool) * 32'(UNIT_BYTES);
    assign w_freeb    = 32'(r_sum) * 32'(UNIT_BYTES);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            fla_pkg::S_CLR: begin
                if (w_clr_last) begin
                    n_state = fla_pkg::S_IDLE;
                end
            end
            fla_pkg::S_IDLE: begin
                if (w_accept) begin
                    case (i_func)
                        fla_pkg::FN_ALLOC, fla_pkg::FN_FREE: n_state = fla_pkg::S_DIV;
                        fla_pkg::FN_STATS: n_state = fla_pkg::S_S_HEAD;
                        default:           n_state = fla_pkg::S_DONE;
                    endcase
                end
            end
            fla_pkg::S_DIV: begin
                if (w_div_done) begin
                    if (r_func == fla_pkg::FN_ALLOC) begin
                        n_state = fla_pkg::S_A_HEAD;
                    end else if (w_bad) begin
                        n_state = fla_pkg::S_DONE;
                    end else begin
                        n_state = fla_pkg::S_F_RD;
                    end
                end
            end
            fla_pkg::S_A_HEAD: n_state = fla_pkg::S_A_HW;
            fla_pkg::S_A_HW:   n_state = fla_pkg::S_A_RD;
            fla_pkg::S_A_RD:   n_state = fla_pkg::S_A_EV;
            fla_pkg::S_A_EV: begin
                if (r_cnt >= CW'(SCAN_LIMIT)) begin
                    n_state = fla_pkg::S_DONE;
                end else if (w_fit) begin
                    n_state = (w_s_u == SW'(r_need)) ? fla_pkg::S_DONE : fla_pkg::S_A_W2;
                end else if (r_p == r_rover) begin
                    n_state = fla_pkg::S_DONE;
                end else begin
                    n_state = fla_pkg::S_A_RD;
                end
            end
            fla_pkg::S_A_W2: n_state = fla_pkg::S_DONE;
            fla_pkg::S_F_RD: n_state = fla_pkg::S_F_EV;
            fla_pkg::S_F_EV: begin
                if (w_brk) begin
                    n_state = fla_pkg::S_F_RB;
                end else if (r_cnt == '0) begin
                    n_state = fla_pkg::S_DONE;
                end else begin
                    n_state = fla_pkg::S_F_RD;
                end
            end
            fla_pkg::S_F_RB:   n_state = fla_pkg::S_F_RU;
            fla_pkg::S_F_RU:   n_state = fla_pkg::S_F_RP;
            fla_pkg::S_F_RP:   n_state = fla_pkg::S_F_WP;
            fla_pkg::S_F_WP:   n_state = fla_pkg::S_DONE;
            fla_pkg::S_S_HEAD: n_state = fla_pkg::S_S_HW;
            fla_pkg::S_S_HW:   n_state = fla_pkg::S_S_RD;
            fla_pkg::S_S_RD:   n_state = fla_pkg::S_S_EV;
            fla_pkg::S_S_EV: begin
                if (r_p == r_rover || r_cnt + 1'b1 >= CW'(SCAN_LIMIT)) begin
                    n_state = fla_pkg::S_DONE;
                end else begin
                    n_state = fla_pkg::S_S_RD;
                end
            end
            fla_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = fla_pkg::S_IDLE;
                end
            end
            default: n_state = fla_pkg::S_CLR;
        endcase
        if (i_cfg_we) begin
            n_state = fla_pkg::S_CLR;
        end
    end

    // datapath and memory control
    always_comb begin
        n_clr_idx  = r_clr_idx;
        n_pool     = r_pool;
        n_rover    = r_rover;
        n_func     = r_func;
        n_need     = r_need;
        n_prev     = r_prev;
        n_p        = r_p;
        n_bp       = r_bp;
        n_up       = r_up;
        n_ub       = r_ub;
        n_nub      = r_nub;
        n_nlb      = r_nlb;
        n_cnt      = r_cnt;
        n_sum      = r_sum;
        n_status   = r_status;
        n_grant    = r_grant;
        n_ov       = r_ov && !i_ready;
        n_o_status = r_o_status;
        n_o_grant  = r_o_grant;
        n_o_total  = r_o_total;
        n_o_free   = r_o_free;
        n_o_used   = r_o_used;
        w_link_we  = 1'b0;
        w_units_we = 1'b0;
        w_link_wa  = r_p;
        w_units_wa = r_p;
        w_link_wd  = '0;
        w_units_wd = '0;
        w_rd_addr  = r_p;
        case (r_state)
            fla_pkg::S_CLR: begin
                w_link_we  = 1'b1;
                w_units_we = 1'b1;
                w_link_wa  = r_clr_idx;
                w_units_wa = r_clr_idx;
                w_link_wd  = (r_clr_idx == '0) ? IW'(1) : '0;
                w_units_wd = (r_clr_idx == IW'(1)) ? r_pool : '0;
                n_clr_idx  = r_clr_idx + 1'b1;
            end
            fla_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_func   = i_func;
                    n_status = fla_pkg::ST_OK;
                    n_grant  = '0;
                end
            end
            fla_pkg::S_DIV: begin
                if (w_div_done) begin
                    n_need = w_payload + NW'(1);
                    n_bp   = IW'(w_div_q);
                    n_p    = r_rover;
                    n_cnt  = CW'(SCAN_LIMIT);
                    if (r_func == fla_pkg::FN_FREE && w_bad) begin
                        n_status = fla_pkg::ST_BADADDR;
                    end
                end
            end
            fla_pkg::S_A_HEAD: begin
                w_rd_addr = r_rover;
                n_prev    = r_rover;
            end
            fla_pkg::S_A_HW: begin
                n_p   = r_link_q;
                n_cnt = '0;
            end
            fla_pkg::S_A_EV: begin
                if (r_cnt >= CW'(SCAN_LIMIT)) begin
                    n_status = fla_pkg::ST_SCAN;
                end else if (w_fit) begin
                    if (w_s_u == SW'(r_need)) begin
                        w_link_we = 1'b1;
                        w_link_wa = r_prev;
                        w_link_wd = r_link_q;
                        n_rover   = r_prev;
                        n_grant   = w_grant_p[fla_pkg::ADDR_W-1:0];
                    end else begin
                        w_units_we = 1'b1;
                        w_units_wa = r_p;
                        w_units_wd = IW'(w_s_u - SW'(r_need));
                        n_p        = IW'(w_fit_top);
                        n_grant    = w_grant_p2[fla_pkg::ADDR_W-1:0];
                    end
                end else if (r_p == r_rover) begin
                    n_status = fla_pkg::ST_NOFIT;
                end else begin
                    n_prev = r_p;
                    n_p    = r_link_q;
                    n_cnt  = r_cnt + 1'b1;
                end
            end
            fla_pkg::S_A_W2: begin
                w_units_we = 1'b1;
                w_units_wa = r_p;
                w_units_wd = IW'(r_need);
                n_rover    = r_prev;
            end
            fla_pkg::S_F_EV: begin
                if (w_brk) begin
                    n_up = r_link_q;
                end else if (r_cnt == '0) begin
                    n_status = fla_pkg::ST_SCAN;
                end else begin
                    n_p   = r_link_q;
                    n_cnt = r_cnt - 1'b1;
                end
            end
            fla_pkg::S_F_RB: begin
                w_rd_addr = r_bp;
            end
            fla_pkg::S_F_RU: begin
                w_rd_addr = r_up;
                n_ub      = r_units_q;
            end
            fla_pkg::S_F_RP: begin
                w_rd_addr  = r_p;
                n_nub      = w_mu ? w_su_sat : r_ub;
                n_nlb      = w_mu ? r_link_q : r_up;
                w_link_we  = 1'b1;
                w_units_we = 1'b1;
                w_link_wa  = r_bp;
                w_units_wa = r_bp;
                w_link_wd  = n_nlb;
                w_units_wd = n_nub;
            end
            fla_pkg::S_F_WP: begin
                w_link_we = 1'b1;
                w_link_wa = r_p;
                if (w_ml) begin
                    w_units_we = 1'b1;
                    w_units_wa = r_p;
                    w_units_wd = w_sl_sat;
                    w_link_wd  = r_nlb;
                end else begin
                    w_link_wd = r_bp;
                end
                n_rover = r_p;
            end
            fla_pkg::S_S_HEAD: begin
                w_rd_addr = r_rover;
            end
            fla_pkg::S_S_HW: begin
                n_p   = r_link_q;
                n_sum = '0;
                n_cnt = '0;
            end
            fla_pkg::S_S_EV: begin
                n_sum = w_ss_sat;
                if (r_p != r_rover) begin
                    n_p   = r_link_q;
                    n_cnt = r_cnt + 1'b1;
                    if (r_cnt + 1'b1 >= CW'(SCAN_LIMIT)) begin
                        n_status = fla_pkg::ST_SCAN;
                    end
                end
            end
            fla_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_ov       = 1'b1;
                    n_o_status = r_status;
                    n_o_grant  = r_grant;
                    n_o_total  = '0;
                    n_o_free   = '0;
                    n_o_used   = '0;
                    if (r_func == fla_pkg::FN_STATS) begin
                        n_o_total = w_total[fla_pkg::BYTES_W-1:0];
                        if (r_status == fla_pkg::ST_OK) begin
                            n_o_free = w_freeb[fla_pkg::BYTES_W-1:0];
                            n_o_used = w_total[fla_pkg::BYTES_W-1:0] -
                                       w_freeb[fla_pkg::BYTES_W-1:0];
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        if (i_cfg_we) begin
            n_pool    = w_cfg_pool;
            n_clr_idx = '0;
            n_rover   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_link_we) begin
            link_mem[w_link_wa] <= w_link_wd;
        end
        r_link_q <= link_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_units_we) begin
            units_mem[w_units_wa] <= w_units_wd;
        end
        r_units_q <= units_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= fla_pkg::S_CLR;
            r_clr_idx <= '0;
            r_pool    <= IW'(POOL_UNITS);
            r_rover   <= '0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
            r_pool    <= n_pool;
            r_rover   <= n_rover;
            r_ov      <= n_ov;
        end
        r_func     <= n_func;
        r_need     <= n_need;
        r_prev     <= n_prev;
        r_p        <= n_p;
        r_bp       <= n_bp;
        r_up       <= n_up;
        r_ub       <= n_ub;
        r_nub      <= n_nub;
        r_nlb      <= n_nlb;
        r_cnt      <= n_cnt;
        r_sum      <= n_sum;
        r_status   <= n_status;
        r_grant    <= n_grant;
        r_o_status <= n_o_status;
        r_o_grant  <= n_o_grant;
        r_o_total  <= n_o_total;
        r_o_free   <= n_o_free;
        r_o_used   <= n_o_used;
    end

    assign o_valid           = r_ov;
    assign o_status          = r_o_status;
    assign o_granted_address = r_o_grant;
    assign o_total_bytes     = r_o_total;
    assign o_free_bytes      = r_o_free;
    assign o_used_bytes      = r_o_used;

endmodule

// ===== sv/fla_chk.sv =====
// ----------------------------------------------------------------------------
// fla_chk: port-level checks of the free-list allocator
// Result channel stability, one request at a time, result field coherence.
// ----------------------------------------------------------------------------
module fla_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_ready,
    input logic [fla_pkg::FUNC_W-1:0]    i_func,
    input logic [fla_pkg::REQ_W-1:0]     i_request_bytes,
    input logic [fla_pkg::ADDR_W-1:0]    i_release_address,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [fla_pkg::STAT_W-1:0]    o_status,
    input logic [fla_pkg::ADDR_W-1:0]    o_granted_address,
    input logic [fla_pkg::BYTES_W-1:0]   o_total_bytes,
    input logic [fla_pkg::BYTES_W-1:0]   o_free_bytes,
    input logic [fla_pkg::BYTES_W-1:0]   o_used_bytes,
    input logic                          i_cfg_we,
    input logic [fla_pkg::CFG_W-1:0]     i_cfg_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_status) &&
                                   $stable(o_granted_address) &&
                                   $stable(o_free_bytes)))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("ready right after a transfer");

    a_fail_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != fla_pkg::ST_OK) |->
        (o_granted_address == '0 && o_free_bytes == '0 && o_used_bytes == '0))
        else $error("failed result carries data");

    a_used_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == fla_pkg::ST_OK) |->
        (o_used_bytes == fla_pkg::BYTES_W'(o_total_bytes - o_free_bytes)))
        else $error("used bytes mismatch");

    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_ready)
        else $error("ready during clearing pass");

endmodule

bind free_list_heap_allocator fla_chk u_fla_chk (.*);

// ===== sim/free_list_heap_allocator_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free_list_heap_allocator_checker: result checker for the heap allocator
// Watches the request, result and configuration ports, keeps its own copy of
// the free list, predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
module free_list_heap_allocator_checker #(
    parameter int POOL_UNITS = 4096,
    parameter int UNIT_BYTES = 8,
    parameter int SCAN_LIMIT = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          i_in_ready,
    input  logic [fla_pkg::FUNC_W-1:0]    i_func,
    input  logic [fla_pkg::REQ_W-1:0]     i_request_bytes,
    input  logic [fla_pkg::ADDR_W-1:0]    i_release_address,
    input  logic                          i_out_valid,
    input  logic                          i_ready,
    input  logic [fla_pkg::STAT_W-1:0]    i_status,
    input  logic [fla_pkg::ADDR_W-1:0]    i_granted_address,
    input  logic [fla_pkg::BYTES_W-1:0]   i_total_bytes,
    input  logic [fla_pkg::BYTES_W-1:0]   i_free_bytes,
    input  logic [fla_pkg::BYTES_W-1:0]   i_used_bytes,
    input  logic                          i_cfg_we,
    input  logic [fla_pkg::CFG_W-1:0]     i_cfg_data,
    output int                            o_fail_count
);

    typedef struct packed {
        logic [fla_pkg::STAT_W-1:0]  status;
        logic [fla_pkg::ADDR_W-1:0]  grant;
        logic [fla_pkg::BYTES_W-1:0] total;
        logic [fla_pkg::BYTES_W-1:0] free_b;
        logic [fla_pkg::BYTES_W-1:0] used;
    } t_result;

    longint unsigned next_run [0:POOL_UNITS];
    longint unsigned run_size [0:POOL_UNITS];
    longint unsigned rover;
    longint unsigned pool_size;
    t_result         pending_results[$];

    function automatic void rebuild_pool();
        for (int i = 0; i <= POOL_UNITS; i++) begin
            next_run[i] = 0;
            run_size[i] = 0;
        end
        next_run[0] = 1;
        run_size[1] = pool_size;
        rover = 0;
    endfunction

    function automatic longint unsigned clamp_pool(longint unsigned v);
        return (v > pool_size) ? pool_size : v;
    endfunction

    function automatic logic [fla_pkg::STAT_W-1:0] carve_block(
        longint unsigned bytes, output longint unsigned grant);
        longint unsigned payload, need, prev, p;
        payload = (bytes + UNIT_BYTES - 1) / UNIT_BYTES;
        grant = 0;
        if (payload == 0) payload = 1;
        need = payload + 1;
        prev = rover;
        p = next_run[prev];
        for (int count = 0; count <= SCAN_LIMIT; count++) begin
            if (count >= SCAN_LIMIT) return fla_pkg::ST_SCAN;
            if (p != 0 && run_size[p] >= need && p + run_size[p] - need <= pool_size) begin
                if (run_size[p] == need) begin
                    next_run[prev] = next_run[p];
                end else begin
                    run_size[p] = run_size[p] - need;
                    p = p + run_size[p];
                    run_size[p] = need;
                end
                rover = prev;
                grant = p * UNIT_BYTES;
                return fla_pkg::ST_OK;
            end
            if (p == rover) return fla_pkg::ST_NOFIT;
            prev = p;
            p = next_run[p];
        end
        return fla_pkg::ST_SCAN;
    endfunction

    function automatic logic [fla_pkg::STAT_W-1:0] release_block(longint unsigned addr);
        longint unsigned bp, p, up;
        int count;
        count = SCAN_LIMIT;
        if (addr == 0 || (addr % UNIT_BYTES) != 0) return fla_pkg::ST_BADADDR;
        bp = addr / UNIT_BYTES;
        if (bp == 0 || bp > pool_size) return fla_pkg::ST_BADADDR;
        p = rover;
        forever begin
            if (bp > p && bp < next_run[p]) break;
            if (p >= next_run[p] && (bp > p || bp < next_run[p])) break;
            if (count == 0) return fla_pkg::ST_SCAN;
            p = next_run[p];
            count--;
        end
        up = next_run[p];
        if (bp + run_size[bp] == up) begin
            run_size[bp] = clamp_pool(run_size[bp] + run_size[up]);
            next_run[bp] = next_run[up];
        end else begin
            next_run[bp] = up;
        end
        if (p + run_size[p] == bp) begin
            run_size[p] = clamp_pool(run_size[p] + run_size[bp]);
            next_run[p] = next_run[bp];
        end else begin
            next_run[p] = bp;
        end
        rover = p;
        return fla_pkg::ST_OK;
    endfunction

    function automatic logic [fla_pkg::STAT_W-1:0] sum_free(
        output longint unsigned free_units);
        longint unsigned sum, p;
        int count;
        sum = 0;
        count = 0;
        free_units = 0;
        p = next_run[rover];
        forever begin
            sum += run_size[p];
            if (p == rover) break;
            p = next_run[p];
            count++;
            if (count >= SCAN_LIMIT) return fla_pkg::ST_SCAN;
        end
        free_units = clamp_pool(sum);
        return fla_pkg::ST_OK;
    endfunction

    function automatic t_result predict_request(logic [fla_pkg::FUNC_W-1:0] fn,
                                                logic [fla_pkg::REQ_W-1:0] req,
                                                logic [fla_pkg::ADDR_W-1:0] rel);
        t_result r;
        longint unsigned grant, fu, total;
        r = '0;
        grant = 0;
        fu = 0;
        case (fn)
            fla_pkg::FN_ALLOC: begin
                r.status = carve_block(req, grant);
                r.grant = grant[fla_pkg::ADDR_W-1:0];
            end
            fla_pkg::FN_FREE: r.status = release_block(rel);
            fla_pkg::FN_STATS: begin
                total = pool_size * UNIT_BYTES;
                r.total = total[fla_pkg::BYTES_W-1:0];
                r.status = sum_free(fu);
                if (r.status == fla_pkg::ST_OK) begin
                    r.free_b = fla_pkg::BYTES_W'(fu * UNIT_BYTES);
                    r.used = fla_pkg::BYTES_W'(total - fu * UNIT_BYTES);
                end
            end
            default: r.status = fla_pkg::ST_OK;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want, got;
        longint unsigned v;
        if (!i_rst_n) begin
            o_fail_count = 0;
            pool_size = POOL_UNITS;
            rebuild_pool();
            pending_results.delete();
        end else begin
            if (i_out_valid && i_ready) begin
                got = '{i_status, i_granted_address, i_total_bytes, i_free_bytes,
                        i_used_bytes};
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, got);
                    o_fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status) begin
                        $display("%0t: status exp %0d got %0d", $time, want.status,
                                 got.status);
                        o_fail_count++;
                    end
                    if (got.grant !== want.grant) begin
                        $display("%0t: granted_address exp %0d got %0d", $time,
                                 want.grant, got.grant);
                        o_fail_count++;
                    end
                    if (got.total !== want.total) begin
                        $display("%0t: total_bytes exp %0d got %0d", $time, want.total,
                                 got.total);
                        o_fail_count++;
                    end
                    if (got.free_b !== want.free_b) begin
                        $display("%0t: free_bytes exp %0d got %0d", $time, want.free_b,
                                 got.free_b);
                        o_fail_count++;
                    end
                    if (got.used !== want.used) begin
                        $display("%0t: used_bytes exp %0d got %0d", $time, want.used,
                                 got.used);
                        o_fail_count++;
                    end
                end
            end
            if (i_valid && i_in_ready)
                pending_results.push_back(predict_request(i_func, i_request_bytes,
                                                          i_release_address));
            if (i_cfg_we) begin
                v = i_cfg_data;
                if (v < 2) v = 2;
                if (v > POOL_UNITS) v = POOL_UNITS;
                pool_size = v;
                rebuild_pool();
            end
        end
    end

    final begin
        if (pending_results.size() != 0)
            $display("%0t: %0d results never arrived", $time, pending_results.size());
    end

endmodule

// ===== sim/free_list_heap_allocator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free_list_heap_allocator_tb: testbench top for the heap allocator
// Drives allocate, free and statistics requests over several pool sizes with
// random gaps and stalls; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module free_list_heap_allocator_tb;

    localparam logic [fla_pkg::FUNC_W-1:0] FN_UNUSED = 2'd3;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_valid;
    logic                        o_ready;
    logic [fla_pkg::FUNC_W-1:0]  i_func;
    logic [fla_pkg::REQ_W-1:0]   i_request_bytes;
    logic [fla_pkg::ADDR_W-1:0]  i_release_address;
    logic                        o_valid;
    logic                        i_ready;
    logic [fla_pkg::STAT_W-1:0]  o_status;
    logic [fla_pkg::ADDR_W-1:0]  o_granted_address;
    logic [fla_pkg::BYTES_W-1:0] o_total_bytes;
    logic [fla_pkg::BYTES_W-1:0] o_free_bytes;
    logic [fla_pkg::BYTES_W-1:0] o_used_bytes;
    logic                        i_cfg_we;
    logic [fla_pkg::CFG_W-1:0]   i_cfg_data;

    int                          fail_count;
    int                          n_sent;
    int                          n_recv;
    int                          n_phases;
    int                          pool_now;
    bit                          no_idle;
    bit                          held_off;
    logic [fla_pkg::ADDR_W-1:0]  live_blocks[$];

    free_list_heap_allocator u_top (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_func, .i_request_bytes,
        .i_release_address, .o_valid, .i_ready, .o_status, .o_granted_address,
        .o_total_bytes, .o_free_bytes, .o_used_bytes, .i_cfg_we, .i_cfg_data
    );

    free_list_heap_allocator_checker u_checker (
        .i_clk, .i_rst_n, .i_valid, .i_in_ready(o_ready), .i_func, .i_request_bytes,
        .i_release_address, .i_out_valid(o_valid), .i_ready, .i_status(o_status),
        .i_granted_address(o_granted_address), .i_total_bytes(o_total_bytes),
        .i_free_bytes(o_free_bytes), .i_used_bytes(o_used_bytes), .i_cfg_we,
        .i_cfg_data, .o_fail_count(fail_count)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        #200ms;
        $display("** free_list_heap_allocator: FAILED **");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) n_sent++;
        if (i_rst_n && o_valid && i_ready) begin
            n_recv++;
            if (o_granted_address != 0) live_blocks.push_back(o_granted_address);
        end
    end

    // result side: random stalls, one long hold-off to back up the request side
    initial begin
        int gap;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 8);
            if (!held_off && n_recv >= 150) begin
                held_off = 1;
                gap = 600;
            end
            @(negedge i_clk);
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    task automatic send_request(logic [fla_pkg::FUNC_W-1:0] fn,
                                logic [fla_pkg::REQ_W-1:0] req,
                                logic [fla_pkg::ADDR_W-1:0] rel);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_func <= fn;
        i_request_bytes <= req;
        i_release_address <= rel;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (n_recv != n_sent) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_pool(logic [fla_pkg::CFG_W-1:0] value);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        live_blocks.delete();
        pool_now = (value < 2) ? 2 : (value > 4096) ? 4096 : value;
        n_phases++;
    endtask

    task automatic free_live();
        int k;
        logic [fla_pkg::ADDR_W-1:0] a;
        if (live_blocks.size() == 0) begin
            send_request(fla_pkg::FN_STATS, fla_pkg::REQ_W'($urandom),
                         fla_pkg::ADDR_W'($urandom));
        end else begin
            k = $urandom_range(0, live_blocks.size() - 1);
            a = live_blocks[k];
            live_blocks.delete(k);
            send_request(fla_pkg::FN_FREE, fla_pkg::REQ_W'($urandom), a);
        end
    endtask

    task automatic run_random(int n);
        int r, top_bytes;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            top_bytes = (pool_now * 8 < 512) ? pool_now * 8 : 512;
            if (r < 45)
                send_request(fla_pkg::FN_ALLOC,
                             fla_pkg::REQ_W'($urandom_range(0, top_bytes)),
                             fla_pkg::ADDR_W'($urandom));
            else if (r < 80)
                free_live();
            else if (r < 88)
                send_request(fla_pkg::FN_STATS, fla_pkg::REQ_W'($urandom),
                             fla_pkg::ADDR_W'($urandom));
            else if (r < 92)
                send_request(fla_pkg::FN_ALLOC, fla_pkg::REQ_W'($urandom),
                             fla_pkg::ADDR_W'($urandom));
            else if (r < 95)
                send_request(fla_pkg::FN_FREE, fla_pkg::REQ_W'($urandom),
                             fla_pkg::ADDR_W'($urandom));
            else if (r < 97)
                send_request(fla_pkg::FN_FREE, fla_pkg::REQ_W'($urandom),
                             fla_pkg::ADDR_W'($urandom_range(1, pool_now) * 8));
            else
                send_request(FN_UNUSED, fla_pkg::REQ_W'($urandom),
                             fla_pkg::ADDR_W'($urandom));
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_func = fla_pkg::FN_ALLOC;
        i_request_bytes = '0;
        i_release_address = '0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        n_phases = 1;
        pool_now = 4096;
        no_idle = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: size extremes, bad addresses, unknown function
        send_request(fla_pkg::FN_ALLOC, 15'd0, 15'd0);
        send_request(fla_pkg::FN_ALLOC, 15'd1, 15'd0);
        send_request(fla_pkg::FN_ALLOC, 15'd8, 15'd0);
        send_request(fla_pkg::FN_ALLOC, 15'd9, 15'd0);
        send_request(fla_pkg::FN_ALLOC, 15'h7fff, 15'h7fff);
        send_request(fla_pkg::FN_STATS, 15'h7fff, 15'h7fff);
        send_request(fla_pkg::FN_FREE, 15'd0, 15'd0);
        send_request(fla_pkg::FN_FREE, 15'd0, 15'd3);
        send_request(fla_pkg::FN_FREE, 15'd0, 15'h7fff);
        send_request(FN_UNUSED, 15'h7fff, 15'h7fff);
        drain();
        repeat (4) free_live();
        send_request(fla_pkg::FN_STATS, 15'd0, 15'd0);
        send_request(fla_pkg::FN_ALLOC, 15'd32752, 15'd0);
        send_request(fla_pkg::FN_ALLOC, 15'd8, 15'd0);
        drain();
        repeat (2) free_live();
        send_request(fla_pkg::FN_STATS, 15'd0, 15'd0);

        run_random(150);
        write_pool(13'd2);
        send_request(fla_pkg::FN_ALLOC, 15'd0, 15'd0);
        send_request(fla_pkg::FN_ALLOC, 15'd0, 15'd0);
        send_request(fla_pkg::FN_STATS, 15'd0, 15'd0);
        drain();
        free_live();
        run_random(30);
        write_pool(13'd0);
        run_random(30);
        write_pool(13'h1fff);
        no_idle = 1;
        run_random(120);
        no_idle = 0;
        write_pool(13'd100);
        run_random(150);
        write_pool(13'd37);
        run_random(120);
        write_pool(13'd4096);
        run_random(180);
        drain();

        $display("Covered %0d requests over %0d pool sizes (2 to 4096 units),", n_sent,
                 n_phases);
        $display("with allocate, free, statistics, bad addresses and stalls.");
        if (fail_count == 0)
            $display("** free_list_heap_allocator: PASSED **");
        else
            $display("** free_list_heap_allocator: FAILED **");
        $finish;
    end

endmodule
